// ===== rtl/core/slefr_pkg.sv =====
// Shared types and constants for the serial frame receiver.
package slefr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned IDX_W  = 6;

    // Framing bytes counted in the length field: start, command, length, end
    localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd4;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h04;

    // Configuration register indexes
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_END  = 3'd4
    } parse_phase_t;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_HOLD = 2'd2
    } emit_state_t;

    // Parser to emitter: frame passed its end check
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  count;
    } emit_req_t;

    // Emitter to parser
    typedef struct packed {
        logic idle;      // no buffer reads pending
        logic out_full;  // output register holds a result
    } emit_status_t;

endpackage

// ===== rtl/core/soh_len_eot_frame_receiver_core.sv =====
// Serial frame receiver: one byte per cycle in; frames emitted from a payload buffer.
// Input: one byte per cycle while no frame is being emitted.
// Output: each result goes through the buffer read register and then the output register;
// an empty frame's result is loaded directly. A new read waits until the previous result is taken.
// Input stalls from the end byte until the final result is loaded for output.
// Reset (aresetn, synchronous, active low) clears control and markers; buffer is not cleared.
module soh_len_eot_frame_receiver_core import slefr_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // rx_byte[7:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // command[7:0], payload_length[14:8],
                                         // byte_index[20:15], data_byte[28:21]
    output logic              m_tuser,   // has_data
    output logic              m_tlast
);

    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    emit_req_t         em_req;
    emit_status_t      em_status;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [BYTE_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;

    slefr_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .AW         (AW)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .em_status  (em_status),
        .em_req     (em_req),
        .mem_wr_en  (mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data)
    );

    slefr_buffer #(
        .DEPTH(MAX_PAYLOAD),
        .AW   (AW)
    ) u_buffer (
        .aclk   (aclk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    slefr_emitter #(
        .AW(AW)
    ) u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .em_req   (em_req),
        .em_status(em_status),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // payload writes never overlap buffer reads of a frame in flight
    a_no_write_during_read: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> em_status.idle)
        else $error("payload write while emitter reads buffer");

    a_start_on_empty_output: assert property (@(posedge aclk) disable iff (!aresetn)
        em_req.start |-> !m_tvalid)
        else $error("emission started with output register occupied");

    a_empty_frame_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[20:15] == 6'd0)))
        else $error("empty frame result malformed");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ({1'b0, m_tdata[20:15]} < m_tdata[14:8]))
        else $error("byte index beyond payload length");
`endif

endmodule

// ===== rtl/core/slefr_buffer.sv =====
// Payload buffer: one write port, one read port with registered read data.
module slefr_buffer import slefr_pkg::*; #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/slefr_parser.sv =====
// Frame parser: marker registers, phase tracking and payload writes.
module slefr_parser import slefr_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 64,
    parameter int unsigned AW          = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  emit_status_t      em_status,
    output emit_req_t         em_req,
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output logic [BYTE_W-1:0] mem_wr_data
);

    localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_PAYLOAD + 4);

    parse_phase_t      phase_reg, phase_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] start_marker_reg, start_marker_next;
    logic [BYTE_W-1:0] end_marker_reg, end_marker_next;

    logic              accept;
    logic [LEN_W-1:0]  fill_inc;
    logic [BYTE_W-1:0] len_payload;
    logic              data_done;

    // The end byte may start an emission, so it waits for an empty output register
    assign s_tready = em_status.idle && ((phase_reg != PH_END) || !em_status.out_full);
    assign accept   = s_tvalid && s_tready;

    assign fill_inc    = fill_reg + 7'd1;
    assign len_payload = len_reg - FRAME_OVERHEAD;
    assign data_done   = ({1'b0, fill_inc} >= len_payload);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_CMD: phase_next = PH_LEN;
                PH_LEN: begin
                    if (s_tdata < FRAME_OVERHEAD) begin
                        phase_next = PH_WAIT;
                    end else if (s_tdata == FRAME_OVERHEAD) begin
                        phase_next = PH_END;
                    end else if (s_tdata > LEN_MAX) begin
                        phase_next = PH_WAIT;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: phase_next = data_done ? PH_END : PH_DATA;
                PH_END:  phase_next = PH_WAIT;
                PH_WAIT: phase_next = (s_tdata == start_marker_reg) ? PH_CMD : PH_WAIT;
                default: phase_next = PH_WAIT;
            endcase
        end
    end

    // Datapath and outputs
    always_comb begin
        cmd_next          = cmd_reg;
        len_next          = len_reg;
        fill_next         = fill_reg;
        start_marker_next = start_marker_reg;
        end_marker_next   = end_marker_reg;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = fill_reg[AW-1:0];
        mem_wr_data       = s_tdata;
        em_req.start      = accept && (phase_reg == PH_END) && (s_tdata == end_marker_reg);
        em_req.command    = cmd_reg;
        em_req.count      = fill_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_START_MARKER: start_marker_next = cfg_wr_data;
                REG_END_MARKER:   end_marker_next   = cfg_wr_data;
                default: ;
            endcase
        end

        if (accept) begin
            case (phase_reg)
                PH_CMD: cmd_next = s_tdata;
                PH_LEN: begin
                    len_next  = s_tdata;
                    fill_next = '0;
                end
                PH_DATA: begin
                    mem_wr_en = 1'b1;
                    fill_next = fill_inc;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_WAIT;
            cmd_reg          <= '0;
            len_reg          <= '0;
            fill_reg         <= '0;
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end else begin
            phase_reg        <= phase_next;
            cmd_reg          <= cmd_next;
            len_reg          <= len_next;
            fill_reg         <= fill_next;
            start_marker_reg <= start_marker_next;
            end_marker_reg   <= end_marker_next;
        end
    end

endmodule

// ===== rtl/core/slefr_emitter.sv =====
// Frame emitter: walks the payload buffer and drives the result channel.
module slefr_emitter import slefr_pkg::*; #(
    parameter int unsigned AW = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  emit_req_t         em_req,
    output emit_status_t      em_status,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [BYTE_W-1:0] rd_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // command[7:0], payload_length[14:8],
                                         // byte_index[20:15], data_byte[28:21]
    output logic              m_tuser,   // has_data
    output logic              m_tlast
);

    emit_state_t       state_reg, state_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_cmd_reg, out_cmd_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_has_reg, out_has_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              take;
    logic [LEN_W-1:0]  idx_inc;
    logic              at_last;

    assign take    = out_valid_reg && m_tready;
    assign idx_inc = idx_reg + 7'd1;
    assign at_last = (idx_inc == count_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE: begin
                if (em_req.start && (em_req.count != '0)) begin
                    state_next = EM_READ;
                end
            end
            EM_READ: state_next = at_last ? EM_IDLE : EM_HOLD;
            EM_HOLD: state_next = take ? EM_READ : EM_HOLD;
            default: state_next = EM_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        out_valid_next = out_valid_reg && !take;
        out_cmd_next   = out_cmd_reg;
        out_len_next   = out_len_reg;
        out_has_next   = out_has_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            EM_IDLE: begin
                if (em_req.start) begin
                    cmd_next   = em_req.command;
                    count_next = em_req.count;
                    idx_next   = '0;
                    if (em_req.count == '0) begin
                        // empty payload: a single marker result
                        out_valid_next = 1'b1;
                        out_cmd_next   = em_req.command;
                        out_len_next   = '0;
                        out_has_next   = 1'b0;
                        out_idx_next   = '0;
                        out_data_next  = '0;
                        out_last_next  = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                end
            end
            EM_READ: begin
                // buffer data for idx_reg is valid this cycle
                out_valid_next = 1'b1;
                out_cmd_next   = cmd_reg;
                out_len_next   = count_reg;
                out_has_next   = 1'b1;
                out_idx_next   = idx_reg[IDX_W-1:0];
                out_data_next  = rd_data;
                out_last_next  = at_last;
                idx_next       = idx_inc;
            end
            EM_HOLD: begin
                if (take) begin
                    rd_en = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= EM_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_cmd_reg  <= out_cmd_next;
        out_len_reg  <= out_len_next;
        out_has_reg  <= out_has_next;
        out_idx_reg  <= out_idx_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign em_status.idle     = (state_reg == EM_IDLE);
    assign em_status.out_full = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg, out_idx_reg, out_len_reg, out_cmd_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/frame_result_checker.sv =====
// Checker for the frame receiver: predicts frame results from accepted bytes and compares.
`timescale 1ns / 1ps

module frame_result_checker import slefr_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // rx_byte[7:0]
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,   // command[7:0], payload_length[14:8],
                                         // byte_index[20:15], data_byte[28:21]
    input  logic              m_tuser,   // has_data
    input  logic              m_tlast,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  length;
        logic              has_data;
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_result_t;

    frame_result_t     frame_results_q[$];
    parse_phase_t      phase;
    logic [BYTE_W-1:0] start_mk;
    logic [BYTE_W-1:0] end_mk;
    logic [BYTE_W-1:0] cmd_hold;
    logic [BYTE_W-1:0] len_hold;
    logic [LEN_W-1:0]  fill;
    logic [BYTE_W-1:0] payload_buf [0:63];

    task automatic push_result(input logic [LEN_W-1:0] n, input logic has,
                               input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                               input logic fin);
        frame_result_t r;
        r.command  = cmd_hold;
        r.length   = n;
        r.has_data = has;
        r.index    = idx;
        r.data     = val;
        r.last     = fin;
        frame_results_q.push_back(r);
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] c);
        int n;
        int i;
        case (phase)
            PH_CMD: begin
                cmd_hold = c;
                phase = PH_LEN;
            end
            PH_LEN: begin
                len_hold = c;
                fill = '0;
                if (c < FRAME_OVERHEAD)
                    phase = PH_WAIT;
                else if (c == FRAME_OVERHEAD)
                    phase = PH_END;
                else if (int'(c) - int'(FRAME_OVERHEAD) > int'(MAX_PAYLOAD))
                    phase = PH_WAIT;
                else
                    phase = PH_DATA;
            end
            PH_DATA: begin
                payload_buf[fill[5:0]] = c;
                fill = fill + 7'd1;
                if (int'(fill) >= int'(len_hold) - int'(FRAME_OVERHEAD))
                    phase = PH_END;
            end
            PH_END: begin
                if (c == end_mk) begin
                    n = (int'(fill) > int'(MAX_PAYLOAD)) ? int'(MAX_PAYLOAD) : int'(fill);
                    if (n == 0) begin
                        push_result('0, 1'b0, '0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < n; i++)
                            push_result(n[LEN_W-1:0], 1'b1, i[IDX_W-1:0],
                                        payload_buf[i[5:0]], i == n - 1);
                    end
                end
                // closing byte is never reused as a start marker
                phase = PH_WAIT;
            end
            default: begin
                phase = (c == start_mk) ? PH_CMD : PH_WAIT;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t exp_r;
        if (!aresetn) begin
            phase    = PH_WAIT;
            start_mk = START_MARKER_RESET;
            end_mk   = END_MARKER_RESET;
            cmd_hold = '0;
            len_hold = '0;
            fill     = '0;
            frame_results_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_START_MARKER)
                    start_mk = cfg_wr_data;
                else if (cfg_addr == REG_END_MARKER)
                    end_mk = cfg_wr_data;
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (frame_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transaction, expected none actual %h",
                             $time, m_tdata);
                end else begin
                    exp_r = frame_results_q.pop_front();
                    check_field("command", 32'(exp_r.command), 32'(m_tdata[7:0]));
                    check_field("payload_length", 32'(exp_r.length), 32'(m_tdata[14:8]));
                    check_field("byte_index", 32'(exp_r.index), 32'(m_tdata[20:15]));
                    check_field("data_byte", 32'(exp_r.data), 32'(m_tdata[28:21]));
                    check_field("has_data", 32'(exp_r.has_data), 32'(m_tuser));
                    check_field("last", 32'(exp_r.last), 32'(m_tlast));
                end
            end
        end
        outstanding = frame_results_q.size();
    end

endmodule

// ===== tb/soh_len_eot_frame_receiver_core_test.sv =====
// Testbench top for the frame receiver: byte and marker stimulus, stalls and verdict.
`timescale 1ns / 1ps

module soh_len_eot_frame_receiver_core_test;
    import slefr_pkg::*;

    localparam int unsigned PAYLOAD_CAP = 64;
    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 200;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic              cfg_addr;
    logic [BYTE_W-1:0] cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    int mismatches;
    int outstanding;

    logic [7:0] cur_start;
    logic [7:0] cur_end;
    int         bytes_sent;
    bit         tx_quiet;
    int         results_seen;
    bit         rx_quiet;
    bit         pressure_armed;
    bit         pressure_done;
    int         idle_cycles;
    logic [7:0] directed_seq [27];

    soh_len_eot_frame_receiver_core #(.MAX_PAYLOAD(PAYLOAD_CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    frame_result_checker #(.MAX_PAYLOAD(PAYLOAD_CAP)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always #5 aclk = ~aclk;

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (bytes_sent % 16 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        @(negedge aclk);
    endtask

    // total is the length byte; payload and closing byte only when it is in range
    task automatic send_frame(input int total, input bit close_ok);
        int i;
        send_byte(cur_start);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(total[7:0]);
        if (total >= 4 && total <= 4 + PAYLOAD_CAP) begin
            for (i = 0; i < total - 4; i++)
                send_byte(8'($urandom_range(0, 255)));
            send_byte(close_ok ? cur_end : cur_end ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_markers(input logic [7:0] sm, input logic [7:0] em);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_START_MARKER;
        cfg_wr_data <= sm;
        @(negedge aclk);
        cfg_addr    <= REG_END_MARKER;
        cfg_wr_data <= em;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_start = sm;
        cur_end   = em;
    endtask

    initial begin
        int ph;
        int base;
        int pick;
        int plen;
        int k;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_START_MARKER;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cur_start   = START_MARKER_RESET;
        cur_end     = END_MARKER_RESET;
        bytes_sent  = 0;
        tx_quiet    = 1'b0;
        pressure_armed = 1'b0;
        directed_seq = '{
            8'h00,                          // noise while waiting
            8'h01, 8'hFF, 8'h03,            // length just below overhead
            8'h01, 8'h00, 8'hFF,            // largest overlong length
            8'h01, 8'hFF, 8'h04, 8'h04,     // empty payload
            8'h01, 8'h04, 8'h06, 8'h01, 8'h04, 8'h04,  // markers inside the frame
            8'h01, 8'h11, 8'h05, 8'hFF, 8'h01, 8'h33,  // bad close equal to start
            8'h01, 8'h22, 8'h04, 8'h04      // must still parse cleanly
        };
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < 27; k++)
            send_byte(directed_seq[k]);

        for (ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: set_markers(8'h00, 8'hFF);
                1: set_markers(8'hFF, 8'h00);
                2: set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: set_markers(START_MARKER_RESET, END_MARKER_RESET);
            endcase
            base = bytes_sent;
            if (ph == 1) begin
                // long hold starts after the first result of the full-size frame
                pressure_armed = 1'b1;
                send_frame(4 + PAYLOAD_CAP, 1'b1);
                send_frame(5 + PAYLOAD_CAP, 1'b1);
            end
            while (bytes_sent - base < 5) begin
                pick = $urandom_range(0, 99);
                plen = ($urandom_range(0, 19) == 0) ? $urandom_range(7, PAYLOAD_CAP)
                                                    : $urandom_range(0, 6);
                if (pick < 70)
                    send_frame(4 + plen, 1'b1);
                else if (pick < 78)
                    send_frame(4 + plen, 1'b0);
                else if (pick < 84)
                    send_frame($urandom_range(0, 3), 1'b1);
                else if (pick < 90)
                    send_frame($urandom_range(5 + PAYLOAD_CAP, 255), 1'b1);
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side: random hold-off per transaction, one long hold to back up the input
    initial begin
        int hold;
        m_tready      = 1'b0;
        results_seen  = 0;
        rx_quiet      = 1'b0;
        pressure_done = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 10);
            if (pressure_armed && !pressure_done) begin
                hold = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
            if (results_seen % 16 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
